[rtl/bucketed_double_hash_table_assert.svh]
// Assertion macros for the bucketed double-hash table checker.
// Expects signals named clock and reset in the using scope.
`ifndef BUCKETED_DOUBLE_HASH_TABLE_ASSERT_SVH
`define BUCKETED_DOUBLE_HASH_TABLE_ASSERT_SVH

// property checked on every clock, off during reset
`define BDHT_CHECK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock, including reset
`define BDHT_CHECK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/bdht_pkg.sv]
// Shared types and constants for the bucketed double-hash table.
// No dependencies.
package bdht_pkg;

   localparam int SLOTS     = 4096;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int KEY_W     = 64;
   localparam int MSIZE_W   = 13;
   localparam int BASE_W    = SLOT_W + MSIZE_W;
   localparam int DIV_BITS  = 4;                    // dividend bits per cycle
   localparam int DIV_STEPS = KEY_W / DIV_BITS;
   localparam int DCNT_W    = $clog2(DIV_STEPS);

   localparam logic [1:0] FN_FIND    = 2'd0;
   localparam logic [1:0] FN_INSERT  = 2'd1;
   localparam logic [1:0] FN_RELEASE = 2'd2;

   localparam logic [1:0] ST_NEW     = 2'd0;
   localparam logic [1:0] ST_PRESENT = 2'd1;
   localparam logic [1:0] ST_MISS    = 2'd2;
   localparam logic [1:0] ST_REJECT  = 2'd3;

   localparam logic [1:0] OP_REJECT  = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_FIND    = 2'd2;
   localparam logic [1:0] OP_INSERT  = 2'd3;

   typedef struct packed {
      logic [1:0]        func;
      logic [KEY_W-1:0]  key;
      logic [11:0]       bucket_index;
      logic [11:0]       slot_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] slot;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]        op;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] base;
      logic [SLOT_W-1:0] offs;
      logic [SLOT_W-1:0] step;
      logic [SLOT_W-1:0] slot;
   } q_entry_type;

endpackage

[rtl/bdht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bdht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/bdht_front.sv]
// Front end: accepts items, screens them and works out the start offset and
// probe step by serial remainder. Uses bdht_pkg.
module bdht_front import bdht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  req_type            req_data,
   input  logic               hold,
   input  logic [MSIZE_W-1:0] msize,
   output logic               front_busy,
   output logic               q_push,
   output q_entry_type        q_entry,
   input  logic               q_full
);
   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_DIV  = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [KEY_W-1:0]   dvd1_ff, dvd1_in, dvd2_ff, dvd2_in;
   logic [MSIZE_W-1:0] r1_ff, r1_in, r2_ff, r2_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   q_entry_type        ent_ff, ent_in;
   logic [MSIZE_W-1:0] mdec;
   logic [MSIZE_W:0]   t1, t2;
   logic               accept, quick_rej;
   logic [BASE_W:0]    span_end;

   assign mdec   = msize - MSIZE_W'(1);
   assign accept = start && !front_busy && !hold;
   assign front_busy = (state_ff != F_IDLE);
   assign span_end = {1'b0, base_ff} + (BASE_W+1)'(msize);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dvd1_in  = dvd1_ff;
      dvd2_in  = dvd2_ff;
      r1_in    = r1_ff;
      r2_in    = r2_ff;
      base_in  = base_ff;
      ent_in   = ent_ff;
      q_push   = 1'b0;
      t1       = '0;
      t2       = '0;
      // unused function code, or a find/insert with empty key or zero size
      quick_rej = (req_data.func != FN_FIND && req_data.func != FN_INSERT &&
                   req_data.func != FN_RELEASE) ||
                  (req_data.func != FN_RELEASE &&
                   (req_data.key == '0 || msize == '0));
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               ent_in.key  = req_data.key;
               ent_in.slot = req_data.slot_in;
               ent_in.offs = '0;
               ent_in.step = '0;
               ent_in.base = '0;
               base_in = BASE_W'(req_data.bucket_index * msize);
               dvd1_in = req_data.key;
               dvd2_in = {5'd0, req_data.key[KEY_W-1:5]} + KEY_W'(1);
               r1_in   = '0;
               r2_in   = '0;
               cnt_in  = '0;
               if (quick_rej) begin
                  ent_in.op = OP_REJECT;
                  state_in  = F_PUSH;
               end else if (req_data.func == FN_RELEASE) begin
                  ent_in.op = OP_RELEASE;
                  state_in  = F_PUSH;
               end else begin
                  ent_in.op = (req_data.func == FN_INSERT) ? OP_INSERT : OP_FIND;
                  state_in  = F_DIV;
               end
            end
         end
         F_DIV: begin
            for (int i = 0; i < DIV_BITS; i++) begin
               t1 = {r1_in, dvd1_ff[KEY_W-1-i]};
               if (t1 >= {1'b0, msize}) t1 = t1 - {1'b0, msize};
               r1_in = t1[MSIZE_W-1:0];
               t2 = {r2_in, dvd2_ff[KEY_W-1-i]};
               if (t2 >= {1'b0, mdec}) t2 = t2 - {1'b0, mdec};
               r2_in = t2[MSIZE_W-1:0];
            end
            dvd1_in = dvd1_ff << DIV_BITS;
            dvd2_in = dvd2_ff << DIV_BITS;
            cnt_in  = cnt_ff + DCNT_W'(1);
            if (cnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = F_PUSH;
               // bucket of one slot: always offset 0
               if (msize < MSIZE_W'(2)) begin
                  ent_in.offs = '0;
                  ent_in.step = '0;
               end else begin
                  ent_in.offs = r1_in[SLOT_W-1:0];
                  ent_in.step = r2_in[SLOT_W-1:0] + SLOT_W'(1);
               end
               if (span_end > (BASE_W+1)'(SLOTS)) ent_in.op = OP_REJECT;
               ent_in.base = base_ff[SLOT_W-1:0];
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign q_entry = ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      dvd1_ff <= dvd1_in;
      dvd2_ff <= dvd2_in;
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      base_ff <= base_in;
      ent_ff  <= ent_in;
   end
endmodule

[rtl/bdht_queue.sv]
// Two-entry queue between front and back ends.
// Uses bdht_pkg.
module bdht_queue import bdht_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_data,
   input  logic        pop,
   output q_entry_type pop_data,
   output logic        full,
   output logic        empty
);
   q_entry_type ent_ff [2];
   q_entry_type ent_in [2];
   logic        wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = ent_ff[rp_ff];

   always_comb begin
      ent_in[0] = ent_ff[0];
      ent_in[1] = ent_ff[1];
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         ent_in[wp_ff] = push_data;
         wp_in = ~wp_ff;
         cnt_in = cnt_in + 2'd1;
      end
      if (pop && !empty) begin
         rp_in = ~rp_ff;
         cnt_in = cnt_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      ent_ff[0] <= ent_in[0];
      ent_ff[1] <= ent_in[1];
   end
endmodule

[rtl/bdht_back.sv]
// Back end: clears the key store after reset, then walks probe sequences,
// claims and releases slots. Uses bdht_pkg and bdht_ram.
module bdht_back import bdht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [MSIZE_W-1:0] msize,
   input  logic               q_empty,
   input  q_entry_type        q_head,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_strobe,
   output rsp_type            rsp_data
);
   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_READ  = 2'd2;
   localparam logic [1:0] B_CHECK = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [SLOT_W:0]    clr_ff, clr_in;
   q_entry_type        cur_ff, cur_in;
   logic [MSIZE_W-1:0] k_ff, k_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;
   logic               we;
   logic [SLOT_W-1:0]  waddr, raddr, haddr;
   logic [KEY_W-1:0]   wdata, rdata;
   logic [SLOT_W:0]    nxt;

   bdht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign haddr    = cur_ff.base + cur_ff.offs;
   assign raddr    = haddr;
   assign clearing = (state_ff == B_CLEAR);
   assign nxt      = {1'b0, cur_ff.offs} + {1'b0, cur_ff.step};

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      q_pop     = 1'b0;
      we        = 1'b0;
      waddr     = haddr;
      wdata     = '0;
      case (state_ff)
         B_CLEAR: begin
            we     = 1'b1;
            waddr  = clr_ff[SLOT_W-1:0];
            clr_in = clr_ff + (SLOT_W+1)'(1);
            if (clr_ff == (SLOT_W+1)'(SLOTS - 1)) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
               k_in   = '0;
               case (q_head.op)
                  OP_REJECT: begin
                     strobe_in     = 1'b1;
                     rsp_in.status = ST_REJECT;
                     rsp_in.slot   = '0;
                  end
                  OP_RELEASE: begin
                     we            = 1'b1;
                     waddr         = q_head.slot;
                     strobe_in     = 1'b1;
                     rsp_in.status = ST_NEW;
                     rsp_in.slot   = q_head.slot;
                  end
                  default: state_in = B_READ;
               endcase
            end
         end
         B_READ: state_in = B_CHECK;
         B_CHECK: begin
            if (cur_ff.op == OP_INSERT && rdata == '0) begin
               we            = 1'b1;
               wdata         = cur_ff.key;
               strobe_in     = 1'b1;
               rsp_in.status = ST_NEW;
               rsp_in.slot   = haddr;
               state_in      = B_IDLE;
            end else if (rdata == cur_ff.key) begin
               strobe_in     = 1'b1;
               rsp_in.status = ST_PRESENT;
               rsp_in.slot   = haddr;
               state_in      = B_IDLE;
            end else if (k_ff == msize - MSIZE_W'(1)) begin
               strobe_in     = 1'b1;
               rsp_in.status = ST_MISS;
               rsp_in.slot   = '0;
               state_in      = B_IDLE;
            end else begin
               k_in = k_ff + MSIZE_W'(1);
               if (nxt >= (SLOT_W+1)'(msize)) begin
                  cur_in.offs = SLOT_W'(nxt - (SLOT_W+1)'(msize));
               end else begin
                  cur_in.offs = nxt[SLOT_W-1:0];
               end
               state_in = B_READ;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_CLEAR;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
      end
      cur_ff <= cur_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end
endmodule

[rtl/bucketed_double_hash_table.sv]
// Bucketed double-hash key store: 4096 x 64-bit keys in buckets of csr size.
// Release and early rejects skip the remainders; find/insert first work out
// serial remainders, 4 key bits a cycle, then probe, up to m probes; a bucket
// past the store is rejected after the remainders. The front takes a new item
// once the last is queued, while the back may still probe. Reset: synchronous;
// a clearing pass over all 4096 slots holds busy high; no result stall.
module bucketed_double_hash_table import bdht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_data,
   output logic               rsp_strobe,
   output rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [MSIZE_W-1:0] csr_wdata
);
   logic [MSIZE_W-1:0] bucket_size_ff, bucket_size_in;
   logic               front_busy, clearing, q_push, q_pop, q_full, q_empty;
   q_entry_type        q_in, q_head;

   assign bucket_size_in = csr_we ? csr_wdata : bucket_size_ff;
   assign busy = front_busy || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_size_ff <= MSIZE_W'(1);
      end else begin
         bucket_size_ff <= bucket_size_in;
      end
   end

   bdht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .hold       (clearing),
      .msize      (bucket_size_ff),
      .front_busy (front_busy),
      .q_push     (q_push),
      .q_entry    (q_in),
      .q_full     (q_full)
   );

   bdht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .pop_data  (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   bdht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .msize      (bucket_size_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );
endmodule

[rtl/bdht_checker.sv]
// Port-level checker for the bucketed double-hash table, bound to the top.
// Uses bdht_pkg and bucketed_double_hash_table_assert.svh.
`include "bucketed_double_hash_table_assert.svh"

module bdht_port_checker import bdht_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);
   `BDHT_CHECK(a_busy_after_beat, start && !busy |=> busy, "busy low after beat")
   `BDHT_CHECK(a_clear_after_reset, $past(reset) |-> busy, "no clearing pass")
   `BDHT_CHECK(a_reject_slot, rsp_strobe && rsp_data.status == ST_REJECT |-> rsp_data.slot == '0, "reject slot")
   `BDHT_CHECK(a_miss_slot, rsp_strobe && rsp_data.status == ST_MISS |-> rsp_data.slot == '0, "miss slot")
   `BDHT_CHECK_ALWAYS(a_quiet_reset, reset |=> !rsp_strobe, "beat right after reset")
endmodule

bind bucketed_double_hash_table bdht_port_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[tb/sv/bdht_checker.sv]
// Checker for the bucketed double-hash table: predicts each beat's answer
// from its own copy of the key store and compares the result strobes.
// Depends on bdht_pkg.
module bdht_checker import bdht_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_data,
   input  logic               rsp_strobe,
   input  rsp_type            rsp_data,
   input  logic               csr_we,
   input  logic [MSIZE_W-1:0] csr_wdata,
   output int                 errors,
   output int                 pending
);

   logic [KEY_W-1:0]   key_mirror [SLOTS];
   logic [MSIZE_W-1:0] bucket_sz;
   rsp_type            answers_due [$];

   function automatic rsp_type lookup_answer(req_type r);
      rsp_type          a;
      logic [63:0]      m;
      logic [63:0]      stride;
      logic [63:0]      base;
      logic [63:0]      h;
      logic [63:0]      k;
      a.status = ST_REJECT;
      a.slot   = '0;
      m = 64'(bucket_sz);
      if (r.func == FN_RELEASE) begin
         key_mirror[r.slot_in] = '0;
         a.status = ST_NEW;
         a.slot   = r.slot_in;
         return a;
      end
      if (r.func != FN_FIND && r.func != FN_INSERT) return a;
      if (r.key == '0 || m == 0) return a;
      base = 64'(r.bucket_index) * m;
      if (base + m > SLOTS) return a;
      stride = (m < 2) ? 64'd0 : 64'd1 + ((r.key >> 5) + 64'd1) % (m - 64'd1);
      for (k = 0; k < m; k++) begin
         h = base + ((m < 2) ? 64'd0 : ((r.key % m) + k * stride) % m);
         if (r.func == FN_INSERT && key_mirror[h] == '0) begin
            key_mirror[h] = r.key;
            a.status = ST_NEW;
            a.slot   = h[11:0];
            return a;
         end
         if (key_mirror[h] == r.key) begin
            a.status = ST_PRESENT;
            a.slot   = h[11:0];
            return a;
         end
      end
      a.status = ST_MISS;
      return a;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) key_mirror[i] = '0;
         bucket_sz = 1;
         answers_due.delete();
         errors = 0;
      end else begin
         if (csr_we) bucket_sz = csr_wdata;
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result status %0d slot %0d",
                        $time, rsp_data.status, rsp_data.slot);
            end else begin
               exp_rsp = answers_due.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d",
                           $time, exp_rsp.status, rsp_data.status);
               end
               if (rsp_data.slot !== exp_rsp.slot) begin
                  errors++;
                  $display("%0t: slot expected %0d actual %0d",
                           $time, exp_rsp.slot, rsp_data.slot);
               end
            end
         end
         // accepted beat; the answer of a beat never comes in its own cycle
         if (start && !busy) answers_due.push_back(lookup_answer(req_data));
      end
      pending = answers_due.size();
   end

endmodule

[tb/sv/tb_bucketed_double_hash_table.sv]
// Testbench top for bucketed_double_hash_table: drives directed and random
// beats through several bucket sizes and gives the verdict.
// Depends on bdht_pkg, bdht_checker and the block itself.
module tb_bucketed_double_hash_table;
   import bdht_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic [MSIZE_W-1:0] csr_wdata = '0;
   int                 errors;
   int                 pending;
   int                 cycles = 0;
   logic [KEY_W-1:0]   key_pool [16];
   bit                 quiet = 1'b0;

   always #5 clock = ~clock;

   bucketed_double_hash_table i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   bdht_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .errors(errors), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_bucketed_double_hash_table: errors");
         $finish;
      end
   end

   function automatic logic [63:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_beat(logic [1:0] fn, logic [63:0] k, logic [11:0] b,
                            logic [11:0] s);
      req_type r;
      r.func = fn;
      r.key = k;
      r.bucket_index = b;
      r.slot_in = s;
      if (!quiet && $urandom_range(0, 99) < 21) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_data <= r;
      start <= 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic drain_and_write(logic [MSIZE_W-1:0] m);
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0 || busy) @(negedge clock);
      repeat (30) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= m;
      @(negedge clock);
      csr_we <= 1'b0;
      for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
   endtask

   task automatic random_beat(int m);
      int          pick;
      int          nbuckets;
      logic [11:0] b;
      logic [63:0] k;
      logic [1:0]  fn;
      logic [11:0] s;
      pick = $urandom_range(0, 99);
      nbuckets = (m > 0) ? SLOTS / m : 1;
      case ($urandom_range(0, 2))
         0: b = 0;
         1: b = (nbuckets > 0) ? 12'(nbuckets - 1) : 12'd0;
         default: b = (nbuckets > 0) ? 12'(nbuckets / 2) : 12'd0;
      endcase
      k = ($urandom_range(0, 9) == 0) ? rand_key() : key_pool[$urandom_range(0, 15)];
      s = (m > 0 && m <= SLOTS) ? 12'(b * m + $urandom_range(0, m - 1)) : 12'($urandom);
      fn = ($urandom_range(0, 1) != 0) ? FN_INSERT : FN_FIND;
      if (pick < 40)      fn = FN_INSERT;
      else if (pick < 75) fn = FN_FIND;
      else if (pick < 88) fn = FN_RELEASE;
      else if (pick < 90) begin
         fn = FN_RELEASE;
         s = 12'($urandom);
      end else if (pick < 93) fn = 2'd3;
      else if (pick < 96) k = '0;
      else b = 12'($urandom);
      send_beat(fn, k, b, s);
   endtask

   initial begin
      int sizes [10]  = '{1, 2, 3, 7, 13, 31, 0, 4096, 8191, 5};
      int counts [10] = '{200, 150, 150, 300, 250, 250, 40, 20, 30, 400};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int p = 0; p < 10; p++) begin
         drain_and_write(MSIZE_W'(sizes[p]));
         quiet = (sizes[p] == 7);
         if (p == 0) begin
            send_beat(FN_FIND, 64'd1, 12'd0, 12'd0);
            send_beat(FN_INSERT, '1, 12'd4095, 12'd0);
            send_beat(FN_INSERT, '1, 12'd4095, 12'd0);
            send_beat(FN_FIND, '1, 12'd4095, 12'd0);
            send_beat(FN_INSERT, 64'h8000_0000_0000_0000, 12'd4095, 12'd0);
            send_beat(2'd3, 64'd5, 12'd3, 12'd3);
            send_beat(FN_INSERT, '0, 12'd1, 12'd0);
            send_beat(FN_FIND, '0, 12'd1, 12'd0);
            send_beat(FN_RELEASE, 64'd0, 12'd0, 12'd4095);
            send_beat(FN_FIND, '1, 12'd4095, 12'd0);
            send_beat(FN_RELEASE, '1, 12'd0, 12'd0);
         end else if (sizes[p] == 2) begin
            send_beat(FN_INSERT, 64'd11, 12'd2047, 12'd0);
            send_beat(FN_INSERT, 64'd12, 12'd2047, 12'd0);
            send_beat(FN_INSERT, 64'd13, 12'd2047, 12'd0);
            send_beat(FN_FIND, 64'd13, 12'd2047, 12'd0);
            send_beat(FN_INSERT, 64'd11, 12'd2048, 12'd0);
         end else if (sizes[p] == 4096) begin
            send_beat(FN_INSERT, 64'd77, 12'd1, 12'd0);
            send_beat(FN_FIND, 64'd78, 12'd0, 12'd0);
         end
         for (int i = 0; i < counts[p]; i++) random_beat(sizes[p]);
      end

      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb_bucketed_double_hash_table: clean");
      end else begin
         $display("tb_bucketed_double_hash_table: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/bdht_pkg.sv
rtl/bdht_ram.sv
rtl/bdht_front.sv
rtl/bdht_queue.sv
rtl/bdht_back.sv
rtl/bucketed_double_hash_table.sv
rtl/bdht_checker.sv
tb/sv/bdht_checker.sv
tb/sv/tb_bucketed_double_hash_table.sv
